### hdl/eye_aspect_ratio_blink_counter_assert.svh
// Assertion macros for the eye aspect ratio blink counter checker
`ifndef EYE_ASPECT_RATIO_BLINK_COUNTER_ASSERT_SVH
`define EYE_ASPECT_RATIO_BLINK_COUNTER_ASSERT_SVH

// Checked only out of reset
`define EARBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("earbc assertion failed");

// Checked during reset as well
`define EARBC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("earbc reset assertion failed");

`endif

### hdl/earbc_pkg.sv
// Package: types, constants and lookup functions of the blink counter
`timescale 1ns / 1ps
`default_nettype none
package earbc_pkg;

  localparam int COORD_W         = 12;
  localparam int COORD_BITS_DEF  = 12;
  localparam int RATIO_FRAC_DEF  = 12;
  localparam int DIST_FRAC_BITS  = 8;
  localparam int RATIO_W         = 16;
  localparam int RUN_W           = 8;
  localparam int BLINK_W         = 16;
  localparam int STORE_DEPTH     = 12;
  localparam int NUM_DIST        = 3;

  localparam logic [RATIO_W-1:0] THRESH_RST  = 16'd1229;
  localparam logic [RUN_W-1:0]   MIN_RUN_RST = 8'd3;
  localparam logic [RUN_W-1:0]   RUN_MAX     = 8'd255;
  localparam logic [RATIO_W-1:0] RATIO_MAX   = 16'hFFFF;

  // Landmark roles
  localparam logic [2:0] ROLE_RIGHT_CORNER = 3'd0;
  localparam logic [2:0] ROLE_LEFT_CORNER  = 3'd1;
  localparam logic [2:0] ROLE_TOP_RIGHT    = 3'd2;
  localparam logic [2:0] ROLE_TOP_LEFT     = 3'd3;
  localparam logic [2:0] ROLE_BOT_RIGHT    = 3'd4;
  localparam logic [2:0] ROLE_BOT_LEFT     = 3'd5;
  localparam logic [2:0] ROLES_PER_EYE     = 3'd6;

  typedef enum logic [0:0] {
    CFG_EAR_THRESHOLD = 1'b0,
    CFG_MIN_CLOSED    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic               eye_side;
    logic [2:0]         landmark_role;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic               frame_last;
  } in_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0] mean_ratio;
    logic               eyes_closed;
    logic               blink_seen;
    logic [BLINK_W-1:0] blink_total;
    logic [RUN_W-1:0]   closed_run;
  } out_item_t;

  // Endpoints of distance k of one eye: A, B, C
  function automatic logic [2:0] role_first(input logic [1:0] k);
    logic [2:0] r;
    unique case (k)
      2'd0:    r = ROLE_BOT_LEFT;
      2'd1:    r = ROLE_BOT_RIGHT;
      default: r = ROLE_LEFT_CORNER;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] role_second(input logic [1:0] k);
    logic [2:0] r;
    unique case (k)
      2'd0:    r = ROLE_TOP_LEFT;
      2'd1:    r = ROLE_TOP_RIGHT;
      default: r = ROLE_RIGHT_CORNER;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/earbc_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module earbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hdl/eye_aspect_ratio_blink_counter.sv
// Top level: landmark store, bit-serial distance/ratio datapath, blink run logic
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (earbc_pkg::in_item_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (earbc_pkg::out_item_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A landmark without frame_last starts no evaluation. A frame_last item then runs
// both eyes, three distances each, through the shift-add squarer and the
// digit-by-digit root, and each eye's ratio through the restoring divider.
// Reset clears the store's valid bits, the run and the blink count, and restores config defaults.
// Inputs are held off while a frame is evaluated, and also while the previous
// result still waits in the output register when the next frame finishes.
`timescale 1ns / 1ps
`default_nettype none
module eye_aspect_ratio_blink_counter #(
  parameter int COORD_BITS      = earbc_pkg::COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = earbc_pkg::RATIO_FRAC_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire earbc_pkg::in_item_t  in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      earbc_pkg::out_item_t out_data_o,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [0:0]           cfg_index_i,
  input  wire logic [15:0]          cfg_data_i
);

  localparam int CW    = (COORD_BITS < earbc_pkg::COORD_W) ? COORD_BITS : earbc_pkg::COORD_W;
  localparam int SQW   = 2 * CW + 1;
  localparam int DF2   = 2 * earbc_pkg::DIST_FRAC_BITS;
  localparam int RN    = (SQW + DF2 + 1) / 2;
  localparam int RADW  = 2 * RN;
  localparam int REMW  = RN + 3;
  localparam int NUMW  = RN + 1 + RATIO_FRAC_BITS;
  localparam int CNTW  = $clog2(NUMW + 1);
  localparam int AW    = $clog2(earbc_pkg::STORE_DEPTH);
  localparam int RW    = earbc_pkg::RATIO_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDA  = 8'b0000_0010,
    S_RDB  = 8'b0000_0100,
    S_SUB  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_SQRT = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [RW-1:0]               thresh_q;
  logic [earbc_pkg::RUN_W-1:0] min_run_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= earbc_pkg::THRESH_RST;
      min_run_q <= earbc_pkg::MIN_RUN_RST;
    end else if (cfg_valid_i) begin
      unique case (earbc_pkg::cfg_idx_e'(cfg_index_i))
        earbc_pkg::CFG_EAR_THRESHOLD: thresh_q  <= cfg_data_i;
        earbc_pkg::CFG_MIN_CLOSED:    min_run_q <= cfg_data_i[earbc_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Landmark store write
  logic           in_acc;
  logic           wr_en;
  logic [AW-1:0]  waddr;
  logic [2*CW-1:0] wdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = in_acc && (in_data_i.landmark_role < earbc_pkg::ROLES_PER_EYE);
  assign waddr      = in_data_i.eye_side
                    ? AW'(earbc_pkg::ROLES_PER_EYE) + AW'(in_data_i.landmark_role)
                    : AW'(in_data_i.landmark_role);
  assign wdata      = {in_data_i.coord_x[CW-1:0], in_data_i.coord_y[CW-1:0]};

  // Sequencer position
  logic       eye_q;
  logic [1:0] dist_q;
  logic [CNTW-1:0] cnt_q;

  // Store read: address follows the sequencer
  logic [AW-1:0]   raddr;
  logic [2:0]      rrole;
  logic [2*CW-1:0] rdata;
  logic [2*CW-1:0] rword;
  logic            rvalid_q;
  logic [earbc_pkg::STORE_DEPTH-1:0] valid_q;

  assign rrole = (state_q == S_RDA) ? earbc_pkg::role_first(dist_q)
                                    : earbc_pkg::role_second(dist_q);
  assign raddr = eye_q ? AW'(earbc_pkg::ROLES_PER_EYE) + AW'(rrole) : AW'(rrole);

  earbc_ram #(
    .WIDTH(2 * CW),
    .DEPTH(earbc_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[waddr] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr];
    end
  end

  assign rword = rvalid_q ? rdata : '0;

  // Datapath registers
  logic [2*CW-1:0] pa_q;
  logic [CW-1:0]   mx_q, my_q;
  logic [SQW-1:0]  ax_q, ay_q, acc_q;
  logic [RADW-1:0] rad_q;
  logic [REMW-1:0] rem_q;
  logic [RN-1:0]   root_q;
  logic [RN-1:0]   da_q, db_q;
  logic            czero_q;
  logic [RN:0]     den_q;
  logic [NUMW-1:0] num_q, quo_q;
  logic [RN+1:0]   drem_q;
  logic [RW-1:0]   r0_q;

  // Absolute coordinate differences
  logic [CW-1:0] ax, ay, bx, by, dx, dy;
  assign ax = pa_q[2*CW-1:CW];
  assign ay = pa_q[CW-1:0];
  assign bx = rword[2*CW-1:CW];
  assign by = rword[CW-1:0];
  assign dx = (ax > bx) ? ax - bx : bx - ax;
  assign dy = (ay > by) ? ay - by : by - ay;

  // Shift-add squaring step, both axes at once
  logic [SQW-1:0] acc_n;
  assign acc_n = acc_q + (mx_q[0] ? ax_q : '0) + (my_q[0] ? ay_q : '0);

  // Digit-by-digit root step
  logic [REMW-1:0] rem_sh, trial, rem_n;
  logic            sq_ge;
  logic [RN-1:0]   root_n;
  assign rem_sh = {rem_q[REMW-3:0], rad_q[RADW-1 -: 2]};
  assign trial  = REMW'({root_q, 2'b01});
  assign sq_ge  = (rem_sh >= trial);
  assign rem_n  = sq_ge ? rem_sh - trial : rem_sh;
  assign root_n = {root_q[RN-2:0], sq_ge};

  // Restoring division step
  logic [RN+1:0]   drem_sh, drem_n;
  logic            dv_ge;
  logic [NUMW-1:0] quo_n;
  logic [RW-1:0]   ratio;
  assign drem_sh = {drem_q[RN:0], num_q[NUMW-1]};
  assign dv_ge   = (drem_sh >= {1'b0, den_q});
  assign drem_n  = dv_ge ? drem_sh - {1'b0, den_q} : drem_sh;
  assign quo_n   = {quo_q[NUMW-2:0], dv_ge};
  assign ratio   = (czero_q || (quo_n[NUMW-1:RW] != '0)) ? earbc_pkg::RATIO_MAX
                                                         : quo_n[RW-1:0];

  // Frame decision
  logic [RW:0]                   mean_sum;
  logic [RW-1:0]                 mean;
  logic                          closed;
  logic [earbc_pkg::RUN_W-1:0]   run_q, run_d;
  logic [earbc_pkg::BLINK_W-1:0] blinks_q, blinks_d;
  logic                          seen;
  logic                          out_valid_q;

  assign mean_sum = {1'b0, r0_q} + {1'b0, ratio};
  assign mean     = mean_sum[RW:1];
  assign closed   = (mean < thresh_q);

  always_comb begin
    run_d    = run_q;
    blinks_d = blinks_q;
    seen     = 1'b0;
    if (closed) begin
      if (run_q != earbc_pkg::RUN_MAX) begin
        run_d = run_q + 1'b1;
      end
    end else begin
      if (run_q >= min_run_q) begin
        blinks_d = blinks_q + 1'b1;
        seen     = 1'b1;
      end
      run_d = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && in_data_i.frame_last) state_d = S_RDA;
      S_RDA:  state_d = S_RDB;
      S_RDB:  state_d = S_SUB;
      S_SUB:  state_d = S_MUL;
      S_MUL:  if (cnt_q == '0) state_d = S_SQRT;
      S_SQRT: if (cnt_q == '0) state_d = (dist_q == 2'(earbc_pkg::NUM_DIST - 1)) ? S_DIV : S_RDA;
      S_DIV:  if (cnt_q == '0) state_d = eye_q ? S_FIN : S_RDA;
      S_FIN:  if (!out_valid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eye_q       <= 1'b0;
      dist_q      <= '0;
      cnt_q       <= '0;
      run_q       <= '0;
      blinks_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          eye_q  <= 1'b0;
          dist_q <= '0;
        end
        S_SUB:  cnt_q <= CNTW'(CW - 1);
        S_MUL:  if (cnt_q == '0) cnt_q <= CNTW'(RN - 1); else cnt_q <= cnt_q - 1'b1;
        S_SQRT: begin
          if (cnt_q == '0) begin
            if (dist_q == 2'(earbc_pkg::NUM_DIST - 1)) begin
              cnt_q <= CNTW'(NUMW - 1);
            end else begin
              dist_q <= dist_q + 1'b1;
            end
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            eye_q  <= 1'b1;
            dist_q <= '0;
            run_q    <= eye_q ? run_d : run_q;
            blinks_q <= eye_q ? blinks_d : blinks_q;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_FIN:  if (!out_valid_q) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers
  earbc_pkg::out_item_t res_q, out_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_RDB: pa_q <= rword;
      S_SUB: begin
        mx_q  <= dx;
        my_q  <= dy;
        ax_q  <= SQW'(dx);
        ay_q  <= SQW'(dy);
        acc_q <= '0;
      end
      S_MUL: begin
        acc_q <= acc_n;
        mx_q  <= mx_q >> 1;
        my_q  <= my_q >> 1;
        ax_q  <= ax_q << 1;
        ay_q  <= ay_q << 1;
        if (cnt_q == '0) begin
          rad_q  <= RADW'({acc_n, {DF2{1'b0}}});
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      S_SQRT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= rem_n;
        root_q <= root_n;
        if (cnt_q == '0) begin
          unique case (dist_q)
            2'd0:    da_q <= root_n;
            2'd1:    db_q <= root_n;
            default: begin
              czero_q <= (root_n == '0);
              den_q   <= {root_n, 1'b0};
              num_q   <= NUMW'({({1'b0, da_q} + {1'b0, db_q}), {RATIO_FRAC_BITS{1'b0}}});
              drem_q  <= '0;
              quo_q   <= '0;
            end
          endcase
        end
      end
      S_DIV: begin
        num_q  <= num_q << 1;
        drem_q <= drem_n;
        quo_q  <= quo_n;
        if (cnt_q == '0) begin
          if (!eye_q) begin
            r0_q <= ratio;
          end else begin
            res_q.mean_ratio  <= mean;
            res_q.eyes_closed <= closed;
            res_q.blink_seen  <= seen;
            res_q.blink_total <= blinks_d;
            res_q.closed_run  <= run_d;
          end
        end
      end
      S_FIN: if (!out_valid_q) out_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### hdl/earbc_chk.sv
// Port-level checker for the blink counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "eye_aspect_ratio_blink_counter_assert.svh"
module earbc_chk (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire earbc_pkg::out_item_t out_data_o
);

  // A stalled result transaction stays offered
  `EARBC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // No result during reset
  `EARBC_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o)

  // A blink is only counted on an open frame
  `EARBC_ASSERT(a_blink_open, out_valid_o && out_data_o.blink_seen |-> !out_data_o.eyes_closed)

  // Run is nonzero exactly on closed frames
  `EARBC_ASSERT(a_run_match, out_valid_o |-> (out_data_o.eyes_closed == (out_data_o.closed_run != 8'd0)))

endmodule

bind eye_aspect_ratio_blink_counter earbc_chk u_earbc_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire
